// File: rtl/core/tun_pkg.sv
// shared widths and word types for the triangle unit normal block
package tun_pkg;

  // coordinate and fraction widths
  localparam int CW = 16;
  localparam int F = 14;

  // edge, product, cross magnitude, square and sum widths
  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int MAGW = 2 * EW - 1;
  localparam int SQW = 2 * MAGW;
  localparam int SW = SQW + 2;

  // residual width of the root cells, quotient and output widths
  localparam int DW = SW + 2 * F + 6;
  localparam int QW = F + 1;
  localparam int OW = F + 2;

  // front pipeline depth
  localparam int FRONT_STAGES = 6;

  typedef logic signed [CW-1:0] coord_t;

  // one component lane inside the cell row
  typedef struct packed {
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] ps;
    logic [QW-1:0] q;
    logic neg;
  } lane_t;

  // word handed from cell to cell
  typedef struct packed {
    logic degen;
    logic [DW-1:0] ss;
    lane_t [2:0] lane;
  } cell_t;

endpackage

// File: rtl/core/tun_front.sv
// front pipeline: edges, cross product, squares and cell row setup
module tun_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  tun_pkg::coord_t [8:0]         p,
  output logic                          out_valid,
  output tun_pkg::cell_t                out_word
);

  logic [tun_pkg::FRONT_STAGES-2:0] v;
  logic signed [tun_pkg::EW-1:0] a [3];
  logic signed [tun_pkg::EW-1:0] b [3];
  logic signed [tun_pkg::PW-1:0] pr [6];
  logic [tun_pkg::MAGW-1:0] mag [3];
  logic neg3 [3];
  logic [tun_pkg::SQW-1:0] sq4 [3];
  logic neg4 [3];
  logic [tun_pkg::SQW-1:0] sq5 [3];
  logic neg5 [3];
  logic [tun_pkg::SW-1:0] s;
  logic signed [tun_pkg::PW-1:0] c [3];

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else begin
      v <= {v[tun_pkg::FRONT_STAGES-3:0], in_valid};
      out_valid <= v[tun_pkg::FRONT_STAGES-2];
    end
  end

  // edges
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a[i] <= tun_pkg::EW'(p[3+i]) - tun_pkg::EW'(p[i]);
      b[i] <= tun_pkg::EW'(p[6+i]) - tun_pkg::EW'(p[i]);
    end
  end

  // cross product partial products
  always_ff @(posedge clk) begin
    pr[0] <= tun_pkg::PW'(a[1]) * tun_pkg::PW'(b[2]);
    pr[1] <= tun_pkg::PW'(a[2]) * tun_pkg::PW'(b[1]);
    pr[2] <= tun_pkg::PW'(a[2]) * tun_pkg::PW'(b[0]);
    pr[3] <= tun_pkg::PW'(a[0]) * tun_pkg::PW'(b[2]);
    pr[4] <= tun_pkg::PW'(a[0]) * tun_pkg::PW'(b[1]);
    pr[5] <= tun_pkg::PW'(a[1]) * tun_pkg::PW'(b[0]);
  end

  // cross components as sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i] = pr[2*i] - pr[2*i+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg3[i] <= c[i][tun_pkg::PW-1];
      mag[i] <= c[i][tun_pkg::PW-1] ? tun_pkg::MAGW'(-c[i]) : tun_pkg::MAGW'(c[i]);
    end
  end

  // squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq4[i] <= tun_pkg::SQW'(mag[i]) * tun_pkg::SQW'(mag[i]);
      neg4[i] <= neg3[i];
    end
  end

  // squared length
  always_ff @(posedge clk) begin
    s <= tun_pkg::SW'(sq4[0]) + tun_pkg::SW'(sq4[1]) + tun_pkg::SW'(sq4[2]);
    for (int i = 0; i < 3; i++) begin
      sq5[i] <= sq4[i];
      neg5[i] <= neg4[i];
    end
  end

  // initial residuals for the top quotient bit
  always_ff @(posedge clk) begin
    out_word.degen <= (s == '0);
    out_word.ss <= tun_pkg::DW'(s) << (2 * tun_pkg::F + 2);
    for (int i = 0; i < 3; i++) begin
      out_word.lane[i].d <= (tun_pkg::DW'(sq5[i]) << (2 * tun_pkg::F + 2))
                            - tun_pkg::DW'(s);
      out_word.lane[i].ps <= -(tun_pkg::DW'(s) << (tun_pkg::F + 2));
      out_word.lane[i].q <= '0;
      out_word.lane[i].neg <= neg5[i];
    end
  end

endmodule

// File: rtl/core/tun_cell.sv
// one quotient bit of the rounded unit normal, three lanes wide
module tun_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  tun_pkg::cell_t in_word,
  output logic           out_valid,
  output tun_pkg::cell_t out_word
);

  logic signed [tun_pkg::DW-1:0] trial [3];
  logic signed [tun_pkg::DW-1:0] ps_new [3];
  logic take [3];
  tun_pkg::cell_t nxt;

  // trial subtract of the odd square step, keep on non-negative
  always_comb begin
    nxt = in_word;
    nxt.ss = in_word.ss >> 2;
    for (int i = 0; i < 3; i++) begin
      trial[i] = in_word.lane[i].d - in_word.lane[i].ps - $signed(in_word.ss);
      take[i] = !trial[i][tun_pkg::DW-1];
      ps_new[i] = take[i] ? in_word.lane[i].ps + $signed(in_word.ss << 1)
                          : in_word.lane[i].ps;
      nxt.lane[i].d = take[i] ? trial[i] : in_word.lane[i].d;
      nxt.lane[i].ps = ps_new[i] >>> 1;
      nxt.lane[i].q = {in_word.lane[i].q[tun_pkg::QW-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= nxt;
  end

endmodule

// File: rtl/core/triangle_unit_normal.sv
// top level: unit normal of one triangle face in signed Q2.14
//
// A face word (three vertices, nine signed 16-bit coordinates) is taken
// at a rising edge where start is high and busy is low. busy is high during
// reset and in the cycle right after it, so a new face may be issued every cycle.
// The result word (normal_x/y/z in Q2.14, degenerate) appears once the face has
// passed the front pipeline, the cell row and the output register, is shown for
// exactly one cycle with done high and is taken at the edge that closes it; the
// receiver cannot stall, so nothing is ever held back.
// Throughput is one face per cycle. The front pipeline takes six stages
// (edges, products, cross, squares, squared length, setup), then a row of
// fifteen cells each settles one quotient bit for all three components by
// a restoring odd-square search, and one output stage applies the sign.
// A face whose cross product is zero gives (0, 0, 1) with degenerate set.
// Reset empties the pipeline; words in flight are dropped.
module triangle_unit_normal (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  tun_pkg::coord_t            p1_x,
  input  tun_pkg::coord_t            p1_y,
  input  tun_pkg::coord_t            p1_z,
  input  tun_pkg::coord_t            p2_x,
  input  tun_pkg::coord_t            p2_y,
  input  tun_pkg::coord_t            p2_z,
  input  tun_pkg::coord_t            p3_x,
  input  tun_pkg::coord_t            p3_y,
  input  tun_pkg::coord_t            p3_z,
  output logic                       done,
  output logic signed [tun_pkg::OW-1:0] normal_x,
  output logic signed [tun_pkg::OW-1:0] normal_y,
  output logic signed [tun_pkg::OW-1:0] normal_z,
  output logic                       degenerate
);

  localparam int LAT = tun_pkg::FRONT_STAGES + tun_pkg::QW + 1;
  localparam logic signed [tun_pkg::OW-1:0] UNIT = tun_pkg::OW'(1) << tun_pkg::F;

  tun_pkg::coord_t [8:0] p;
  logic accept;
  logic cv [tun_pkg::QW+1];
  tun_pkg::cell_t cw [tun_pkg::QW+1];
  logic signed [tun_pkg::OW-1:0] comp [3];
  tun_pkg::cell_t last;

  assign p = {p3_z, p3_y, p3_x, p2_z, p2_y, p2_x, p1_z, p1_y, p1_x};
  assign accept = start && !busy;

  // busy covers the cycle right after reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  tun_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .p         (p),
    .out_valid (cv[0]),
    .out_word  (cw[0])
  );

  // row of quotient cells, top bit first
  for (genvar k = 0; k < tun_pkg::QW; k++) begin : g_cell
    tun_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_word   (cw[k]),
      .out_valid (cv[k+1]),
      .out_word  (cw[k+1])
    );
  end

  assign last = cw[tun_pkg::QW];

  // apply signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp[i] = last.lane[i].neg ? -tun_pkg::OW'(last.lane[i].q)
                                 : tun_pkg::OW'(last.lane[i].q);
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[tun_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    degenerate <= last.degen;
    if (last.degen) begin
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= UNIT;
    end else begin
      normal_x <= comp[0];
      normal_y <= comp[1];
      normal_z <= comp[2];
    end
  end

  // an accepted face comes out after the fixed latency
  assert property (@(posedge clk) disable iff (rst) accept |-> ##LAT done)
    else $error("face result missing at fixed latency");

  // degenerate faces give the default normal
  assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == '0 && normal_y == '0
                           && normal_z == UNIT)
    else $error("degenerate face without default normal");

  // a proper face never gives a zero normal
  assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> normal_x != '0 || normal_y != '0
                            || normal_z != '0)
    else $error("zero normal on a proper face");

  // x and y components stay within unit range
  assert property (@(posedge clk) disable iff (rst)
    done |-> normal_x <= UNIT && normal_x >= -UNIT
             && normal_y <= UNIT && normal_y >= -UNIT)
    else $error("normal component out of range");

endmodule
